### hdl/rope_pkg.sv
// Shared types, constants and arithmetic helpers for the bf16 rotary embedding pair unit.
`default_nettype none
package rope_pkg;

   localparam int LATENCY = 7;
   localparam int MAG_W   = 45;

   localparam logic signed [11:0] EMIN     = -12'sd149;
   localparam logic signed [11:0] EMAX     = 12'sd127;
   localparam logic signed [11:0] FAR_DIST = 12'sd26;
   localparam logic [31:0]        F32_NAN  = 32'h7FC0_0000;
   localparam logic [15:0]        BF16_NAN = 16'h7FC0;

   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_FIN,
      CLS_INF,
      CLS_NAN
   } cls_type;

   // Value is mant * 2^expo when the class is finite.
   typedef struct packed {
      cls_type            cls;
      logic               sign;
      logic [16:0]        mant;
      logic signed [11:0] expo;
   } num_type;

   typedef struct packed {
      logic               spec;
      logic [31:0]        spec_bits;
      logic               sign;
      logic [MAG_W-1:0]   mag;
      logic signed [11:0] expo;
   } sum_type;

   function automatic num_type decode_bf16(input logic [15:0] h);
      num_type n;
      n.sign = h[15];
      n.mant = 17'd0;
      n.expo = 12'sd0;
      if (h[14:7] == 8'hFF) begin
         n.cls = (h[6:0] != 7'd0) ? CLS_NAN : CLS_INF;
      end else if (h[14:7] == 8'h00) begin
         n.cls  = (h[6:0] != 7'd0) ? CLS_FIN : CLS_ZERO;
         n.mant = {10'd0, h[6:0]};
         n.expo = -12'sd133;
      end else begin
         n.cls  = CLS_FIN;
         n.mant = {9'd0, 1'b1, h[6:0]};
         n.expo = $signed({4'd0, h[14:7]}) - 12'sd134;
      end
      return n;
   endfunction

   function automatic cls_type mul_cls(input cls_type a, input cls_type b);
      cls_type c;
      if (a == CLS_NAN || b == CLS_NAN) begin
         c = CLS_NAN;
      end else if ((a == CLS_INF && b == CLS_ZERO) || (a == CLS_ZERO && b == CLS_INF)) begin
         c = CLS_NAN;
      end else if (a == CLS_INF || b == CLS_INF) begin
         c = CLS_INF;
      end else if (a == CLS_ZERO || b == CLS_ZERO) begin
         c = CLS_ZERO;
      end else begin
         c = CLS_FIN;
      end
      return c;
   endfunction

   function automatic logic [4:0] top17(input logic [16:0] v);
      logic [4:0] t;
      t = 5'd0;
      for (int i = 0; i < 17; i++) begin
         if (v[i]) begin
            t = 5'(i);
         end
      end
      return t;
   endfunction

   function automatic logic [5:0] top45(input logic [MAG_W-1:0] v);
      logic [5:0] t;
      t = 6'd0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            t = 6'(i);
         end
      end
      return t;
   endfunction

endpackage
`default_nettype wire

### hdl/rope_lane.sv
// One fused rotate lane: fma(a, b, round(x * y)) rounded to bfloat16, seven register stages.
`default_nettype none
module rope_lane (
   input  wire logic        clock,
   input  wire logic [15:0] a_bits,
   input  wire logic [15:0] b_bits,
   input  wire logic [15:0] x_bits,
   input  wire logic [15:0] y_bits,
   output logic [15:0]      rot_bits
);

   rope_pkg::num_type p1_in, p1_ff, c1_in, c1_ff;
   rope_pkg::num_type p2_in, p2_ff, c2_in, c2_ff;
   rope_pkg::num_type p3_in, p3_ff, c3_in, c3_ff;
   rope_pkg::sum_type s4_in, s4_ff, s5_ff;
   logic [5:0]  t5_in, t5_ff;
   logic [31:0] u6_in, u6_ff;
   logic [15:0] out_in, out_ff;

   // Stage 1: decode and form both exact products.
   always_comb begin
      rope_pkg::num_type a, b, x, y;
      logic [15:0] pm, cm;
      a  = rope_pkg::decode_bf16(a_bits);
      b  = rope_pkg::decode_bf16(b_bits);
      x  = rope_pkg::decode_bf16(x_bits);
      y  = rope_pkg::decode_bf16(y_bits);
      pm = a.mant[7:0] * b.mant[7:0];
      cm = x.mant[7:0] * y.mant[7:0];
      p1_in.cls  = rope_pkg::mul_cls(a.cls, b.cls);
      p1_in.sign = a.sign ^ b.sign;
      p1_in.mant = {1'b0, pm};
      p1_in.expo = a.expo + b.expo;
      c1_in.cls  = rope_pkg::mul_cls(x.cls, y.cls);
      c1_in.sign = x.sign ^ y.sign;
      c1_in.mant = {1'b0, cm};
      c1_in.expo = x.expo + y.expo;
   end

   // Stage 2: round the plain product to single precision.
   always_comb begin
      logic [4:0]         tc, sa, sa1;
      logic signed [11:0] tsum, shc;
      logic [16:0]        q, m;
      logic               guard, sticky;
      p2_in  = p1_ff;
      c2_in  = c1_ff;
      tc     = rope_pkg::top17(c1_ff.mant);
      tsum   = $signed({7'd0, tc}) + c1_ff.expo;
      shc    = rope_pkg::EMIN - c1_ff.expo;
      sa     = shc[4:0];
      sa1    = sa - 5'd1;
      q      = c1_ff.mant >> sa;
      guard  = |((c1_ff.mant >> sa1) & 17'd1);
      sticky = |(c1_ff.mant & ~(17'h1FFFF << sa1));
      m      = q + {16'd0, guard & (sticky | q[0])};
      if (c1_ff.cls == rope_pkg::CLS_FIN) begin
         if (tsum > rope_pkg::EMAX) begin
            c2_in.cls = rope_pkg::CLS_INF;
         end else if (c1_ff.expo < rope_pkg::EMIN) begin
            if (shc >= 12'sd17 || m == 17'd0) begin
               c2_in.cls = rope_pkg::CLS_ZERO;
            end else begin
               c2_in.mant = m;
               c2_in.expo = rope_pkg::EMIN;
            end
         end
      end
   end

   // Stage 3: normalize both operands so bit 16 is set.
   always_comb begin
      logic [4:0] kp, kc;
      p3_in = p2_ff;
      c3_in = c2_ff;
      kp    = 5'd16 - rope_pkg::top17(p2_ff.mant);
      kc    = 5'd16 - rope_pkg::top17(c2_ff.mant);
      if (p2_ff.cls == rope_pkg::CLS_FIN) begin
         p3_in.mant = p2_ff.mant << kp;
         p3_in.expo = p2_ff.expo - $signed({7'd0, kp});
      end
      if (c2_ff.cls == rope_pkg::CLS_FIN) begin
         c3_in.mant = c2_ff.mant << kc;
         c3_in.expo = c2_ff.expo - $signed({7'd0, kc});
      end
   end

   // Stage 4: special cases, alignment and the exact add.
   always_comb begin
      rope_pkg::num_type big, sml;
      logic signed [11:0] d;
      logic [rope_pkg::MAG_W-1:0] bm, sm;
      s4_in = '0;
      if (p3_ff.expo >= c3_ff.expo) begin
         big = p3_ff;
         sml = c3_ff;
      end else begin
         big = c3_ff;
         sml = p3_ff;
      end
      d = big.expo - sml.expo;
      if (d > rope_pkg::FAR_DIST) begin
         // The smaller term lies wholly below the rounding point and acts as sticky.
         bm = {28'd0, big.mant} << 27;
         sm = 45'd1;
      end else begin
         bm = {28'd0, big.mant} << d[4:0];
         sm = {28'd0, sml.mant};
      end
      if (p3_ff.cls == rope_pkg::CLS_NAN || c3_ff.cls == rope_pkg::CLS_NAN) begin
         s4_in.spec      = 1'b1;
         s4_in.spec_bits = rope_pkg::F32_NAN;
      end else if (p3_ff.cls == rope_pkg::CLS_INF || c3_ff.cls == rope_pkg::CLS_INF) begin
         s4_in.spec = 1'b1;
         if (p3_ff.cls == rope_pkg::CLS_INF && c3_ff.cls == rope_pkg::CLS_INF &&
             p3_ff.sign != c3_ff.sign) begin
            s4_in.spec_bits = rope_pkg::F32_NAN;
         end else if (p3_ff.cls == rope_pkg::CLS_INF) begin
            s4_in.spec_bits = {p3_ff.sign, 31'h7F80_0000};
         end else begin
            s4_in.spec_bits = {c3_ff.sign, 31'h7F80_0000};
         end
      end else if (p3_ff.cls == rope_pkg::CLS_ZERO && c3_ff.cls == rope_pkg::CLS_ZERO) begin
         s4_in.spec      = 1'b1;
         s4_in.spec_bits = {p3_ff.sign & c3_ff.sign, 31'd0};
      end else if (p3_ff.cls == rope_pkg::CLS_ZERO) begin
         s4_in.sign = c3_ff.sign;
         s4_in.mag  = {28'd0, c3_ff.mant};
         s4_in.expo = c3_ff.expo;
      end else if (c3_ff.cls == rope_pkg::CLS_ZERO) begin
         s4_in.sign = p3_ff.sign;
         s4_in.mag  = {28'd0, p3_ff.mant};
         s4_in.expo = p3_ff.expo;
      end else begin
         s4_in.expo = (d > rope_pkg::FAR_DIST) ? big.expo - 12'sd27 : sml.expo;
         if (big.sign == sml.sign) begin
            s4_in.mag  = bm + sm;
            s4_in.sign = big.sign;
         end else if (bm >= sm) begin
            s4_in.mag  = bm - sm;
            s4_in.sign = big.sign;
         end else begin
            s4_in.mag  = sm - bm;
            s4_in.sign = sml.sign;
         end
      end
   end

   // Stage 5: leading-one search over the sum.
   assign t5_in = rope_pkg::top45(s4_ff.mag);

   // Stage 6: round the sum once to single precision.
   always_comb begin
      logic signed [11:0] lsb, sh, nsh;
      logic [5:0]  shr, shr1;
      logic [rope_pkg::MAG_W-1:0] q, lsh;
      logic [24:0] m;
      logic        guard, sticky;
      lsb    = $signed({6'd0, t5_ff}) + s5_ff.expo - 12'sd23;
      if (lsb < rope_pkg::EMIN) begin
         lsb = rope_pkg::EMIN;
      end
      sh     = lsb - s5_ff.expo;
      nsh    = -sh;
      shr    = sh[5:0];
      shr1   = shr - 6'd1;
      q      = s5_ff.mag >> shr;
      lsh    = s5_ff.mag << nsh[4:0];
      guard  = |((s5_ff.mag >> shr1) & 45'd1);
      sticky = |(s5_ff.mag & ~({rope_pkg::MAG_W{1'b1}} << shr1));
      if (sh <= 12'sd0) begin
         m = lsh[24:0];
      end else if (sh >= 12'sd46) begin
         m = 25'd0;
      end else begin
         m = q[24:0] + {24'd0, guard & (sticky | q[0])};
      end
      if (m[24]) begin
         m   = m >> 1;
         lsb = lsb + 12'sd1;
      end
      if (s5_ff.spec) begin
         u6_in = s5_ff.spec_bits;
      end else if (s5_ff.mag == '0) begin
         u6_in = 32'd0;
      end else if (m == 25'd0) begin
         u6_in = {s5_ff.sign, 31'd0};
      end else if (m[23]) begin
         if (lsb + 12'sd23 > rope_pkg::EMAX) begin
            u6_in = {s5_ff.sign, 31'h7F80_0000};
         end else begin
            u6_in = {s5_ff.sign, 8'(lsb + 12'sd150), m[22:0]};
         end
      end else begin
         u6_in = {s5_ff.sign, 8'd0, m[22:0]};
      end
   end

   // Stage 7: single to bfloat16, nearest-even.
   always_comb begin
      logic [32:0] r;
      r = {1'b0, u6_ff} + 33'h0_7FFF + {32'd0, u6_ff[16]};
      if (u6_ff[30:23] == 8'hFF && u6_ff[22:0] != 23'd0) begin
         out_in = rope_pkg::BF16_NAN;
      end else begin
         out_in = r[31:16];
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      c1_ff  <= c1_in;
      p2_ff  <= p2_in;
      c2_ff  <= c2_in;
      p3_ff  <= p3_in;
      c3_ff  <= c3_in;
      s4_ff  <= s4_in;
      s5_ff  <= s4_ff;
      t5_ff  <= t5_in;
      u6_ff  <= u6_in;
      out_ff <= out_in;
   end

   assign rot_bits = out_ff;

endmodule
`default_nettype wire

### hdl/bf16_rotary_embedding_pair_unit.sv
// Top level: four rotate lanes for the query and key pairs and the result strobe pipeline.
// Each result strobe runs through a shift register as deep as the lane pipeline, so it lines up with the lane outputs.
// Throughput: one item per cycle; busy stays low and every lane is fully pipelined.
// Reset clears only the strobe pipeline, so no stale result is signaled after reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module bf16_rotary_embedding_pair_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_q_first,
   input  wire logic [15:0] req_q_second,
   input  wire logic [15:0] req_k_first,
   input  wire logic [15:0] req_k_second,
   input  wire logic [15:0] req_cos_val,
   input  wire logic [15:0] req_sin_val,
   output logic             rsp_valid,
   output logic [15:0]      rsp_q_rot_first,
   output logic [15:0]      rsp_q_rot_second,
   output logic [15:0]      rsp_k_rot_first,
   output logic [15:0]      rsp_k_rot_second
);

   logic [rope_pkg::LATENCY-1:0] valid_in, valid_ff;

   assign busy = 1'b0;

   // The first output uses the negated second element as the fused multiplicand.
   rope_lane u_q_first (
      .clock    (clock),
      .a_bits   ({~req_q_second[15], req_q_second[14:0]}),
      .b_bits   (req_sin_val),
      .x_bits   (req_q_first),
      .y_bits   (req_cos_val),
      .rot_bits (rsp_q_rot_first)
   );

   rope_lane u_q_second (
      .clock    (clock),
      .a_bits   (req_q_first),
      .b_bits   (req_sin_val),
      .x_bits   (req_q_second),
      .y_bits   (req_cos_val),
      .rot_bits (rsp_q_rot_second)
   );

   rope_lane u_k_first (
      .clock    (clock),
      .a_bits   ({~req_k_second[15], req_k_second[14:0]}),
      .b_bits   (req_sin_val),
      .x_bits   (req_k_first),
      .y_bits   (req_cos_val),
      .rot_bits (rsp_k_rot_first)
   );

   rope_lane u_k_second (
      .clock    (clock),
      .a_bits   (req_k_first),
      .b_bits   (req_sin_val),
      .x_bits   (req_k_second),
      .y_bits   (req_cos_val),
      .rot_bits (rsp_k_rot_second)
   );

   assign valid_in = {valid_ff[rope_pkg::LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[rope_pkg::LATENCY-1];

endmodule
`default_nettype wire

### sim/bf16_rotary_embedding_pair_unit_checker.sv
// Checker for the bf16 rotary pair unit: predicts each rotated result and compares it.
`timescale 1ns / 1ps
module bf16_rotary_embedding_pair_unit_checker
   import rope_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [15:0] req_q_first,
   input  wire logic [15:0] req_q_second,
   input  wire logic [15:0] req_k_first,
   input  wire logic [15:0] req_k_second,
   input  wire logic [15:0] req_cos_val,
   input  wire logic [15:0] req_sin_val,
   input  wire logic        rsp_valid,
   input  wire logic [15:0] rsp_q_rot_first,
   input  wire logic [15:0] rsp_q_rot_second,
   input  wire logic [15:0] rsp_k_rot_first,
   input  wire logic [15:0] rsp_k_rot_second,
   output int               fail_count,
   output int               outstanding
);

   localparam int FAR_ALIGN = 38;

   typedef struct {
      cls_type         cls;
      bit              sign;
      longint unsigned mant;
      int              ex;
   } fp_val;

   typedef struct {
      bit [15:0] q_first;
      bit [15:0] q_second;
      bit [15:0] k_first;
      bit [15:0] k_second;
   } rot_result;

   rot_result rotated_q[$];

   function automatic fp_val unpack_f32(input bit [31:0] u);
      fp_val n;
      n.sign = u[31];
      n.mant = 0;
      n.ex   = 0;
      if (u[30:23] == 8'hFF) begin
         n.cls = (u[22:0] != 0) ? CLS_NAN : CLS_INF;
      end else if (u[30:23] == 8'h00) begin
         n.cls = (u[22:0] != 0) ? CLS_FIN : CLS_ZERO;
         n.mant = u[22:0];
         n.ex = -149;
         if (n.cls == CLS_FIN) begin
            while (n.mant < 64'h80_0000) begin
               n.mant = n.mant << 1;
               n.ex--;
            end
         end
      end else begin
         n.cls  = CLS_FIN;
         n.mant = {1'b1, u[22:0]};
         n.ex   = int'(u[30:23]) - 150;
      end
      return n;
   endfunction

   // Round sign * mag * 2^e to single precision, nearest-even, subnormals kept.
   function automatic bit [31:0] round_single(input bit s, input longint unsigned mag,
                                              input int e);
      int top, lsb, sh;
      longint unsigned m, q, rem, half;
      top = 62;
      while (mag[top] == 1'b0) top--;
      lsb = top + e - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - e;
      if (sh <= 0) begin
         m = mag << (-sh);
      end else if (sh >= 64) begin
         m = 0;
      end else begin
         q = mag >> sh;
         rem = mag & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         m = q;
         if (rem > half || (rem == half && q[0])) m = q + 1;
      end
      if ((m >> 24) != 0) begin
         m = m >> 1;
         lsb++;
      end
      if (m == 0) return {s, 31'd0};
      if (m >= 64'h80_0000) begin
         if (lsb + 23 > 127) return {s, 31'h7F80_0000};
         return {s, 8'(lsb + 150), m[22:0]};
      end
      return {s, 8'd0, m[22:0]};
   endfunction

   function automatic bit [31:0] pack_f32(input fp_val n);
      case (n.cls)
         CLS_NAN:  return F32_NAN;
         CLS_INF:  return {n.sign, 31'h7F80_0000};
         CLS_ZERO: return {n.sign, 31'd0};
         default:  return round_single(n.sign, n.mant, n.ex);
      endcase
   endfunction

   function automatic fp_val exact_product(input fp_val a, input fp_val b);
      fp_val p;
      p.sign = a.sign ^ b.sign;
      p.mant = 0;
      p.ex = 0;
      if (a.cls == CLS_NAN || b.cls == CLS_NAN) begin
         p.cls = CLS_NAN;
      end else if ((a.cls == CLS_INF && b.cls == CLS_ZERO) ||
                   (a.cls == CLS_ZERO && b.cls == CLS_INF)) begin
         p.cls = CLS_NAN;
      end else if (a.cls == CLS_INF || b.cls == CLS_INF) begin
         p.cls = CLS_INF;
      end else if (a.cls == CLS_ZERO || b.cls == CLS_ZERO) begin
         p.cls = CLS_ZERO;
      end else begin
         p.cls = CLS_FIN;
         p.mant = (a.mant * b.mant) >> 24;
         p.ex = a.ex + b.ex + 24;
         while (p.mant < 64'h80_0000) begin
            p.mant = p.mant << 1;
            p.ex--;
         end
      end
      return p;
   endfunction

   // Exact sum of the product and the addend, rounded once to single.
   function automatic bit [31:0] sum_single(input fp_val p, input fp_val c);
      fp_val hi, lo;
      int d, e;
      longint unsigned hm, lm, mag;
      bit s;
      if (p.cls == CLS_NAN || c.cls == CLS_NAN) return F32_NAN;
      if (p.cls == CLS_INF || c.cls == CLS_INF) begin
         if (p.cls == CLS_INF && c.cls == CLS_INF && p.sign != c.sign) return F32_NAN;
         return {(p.cls == CLS_INF) ? p.sign : c.sign, 31'h7F80_0000};
      end
      if (p.cls == CLS_ZERO && c.cls == CLS_ZERO) return {p.sign & c.sign, 31'd0};
      if (p.cls == CLS_ZERO) return pack_f32(c);
      if (c.cls == CLS_ZERO) return pack_f32(p);
      if (p.ex >= c.ex) begin
         hi = p;
         lo = c;
      end else begin
         hi = c;
         lo = p;
      end
      d = hi.ex - lo.ex;
      if (d > FAR_ALIGN) begin
         // The smaller term only acts as a sticky bit far below the rounding point.
         hm = hi.mant << FAR_ALIGN;
         lm = 1;
         e = hi.ex - FAR_ALIGN;
      end else begin
         hm = hi.mant << d;
         lm = lo.mant;
         e = lo.ex;
      end
      if (hi.sign == lo.sign) begin
         mag = hm + lm;
         s = hi.sign;
      end else if (hm >= lm) begin
         mag = hm - lm;
         s = hi.sign;
      end else begin
         mag = lm - hm;
         s = lo.sign;
      end
      if (mag == 0) return 32'd0;
      return round_single(s, mag, e);
   endfunction

   function automatic bit [15:0] single_to_bf16(input bit [31:0] u);
      if (u[30:23] == 8'hFF && u[22:0] != 0) return BF16_NAN;
      u = u + 32'h7FFF + u[16];
      return u[31:16];
   endfunction

   // a*b + round(x*y), one fused rounding, then to bf16.
   function automatic bit [15:0] fused_bf16(input fp_val a, input fp_val b,
                                            input fp_val x, input fp_val y);
      fp_val addend;
      addend = unpack_f32(pack_f32(exact_product(x, y)));
      return single_to_bf16(sum_single(exact_product(a, b), addend));
   endfunction

   function automatic void rotate_pair(input bit [15:0] first, input bit [15:0] second,
                                       input bit [15:0] cosv, input bit [15:0] sinv,
                                       output bit [15:0] out_first,
                                       output bit [15:0] out_second);
      fp_val f, g, ng, c, s;
      f = unpack_f32({first, 16'd0});
      g = unpack_f32({second, 16'd0});
      c = unpack_f32({cosv, 16'd0});
      s = unpack_f32({sinv, 16'd0});
      ng = g;
      ng.sign = ~g.sign;
      out_first = fused_bf16(ng, s, f, c);
      out_second = fused_bf16(f, s, g, c);
   endfunction

   function automatic void compare_field(input string name, input bit [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, want, got);
         fail_count++;
      end
   endfunction

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      rot_result r, want;
      if (!reset) begin
         if (start && !busy) begin
            rotate_pair(req_q_first, req_q_second, req_cos_val, req_sin_val,
                        r.q_first, r.q_second);
            rotate_pair(req_k_first, req_k_second, req_cos_val, req_sin_val,
                        r.k_first, r.k_second);
            rotated_q.push_back(r);
         end
         if (rsp_valid) begin
            if (rotated_q.size() == 0) begin
               $display("%0t: result with none expected: expected nothing, actual %h %h %h %h",
                        $realtime, rsp_q_rot_first, rsp_q_rot_second, rsp_k_rot_first,
                        rsp_k_rot_second);
               fail_count++;
            end else begin
               want = rotated_q.pop_front();
               compare_field("q_rot_first", want.q_first, rsp_q_rot_first);
               compare_field("q_rot_second", want.q_second, rsp_q_rot_second);
               compare_field("k_rot_first", want.k_first, rsp_k_rot_first);
               compare_field("k_rot_second", want.k_second, rsp_k_rot_second);
            end
         end
         outstanding <= rotated_q.size();
      end
   end

endmodule

### sim/bf16_rotary_embedding_pair_unit_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the bf16 rotary pair unit.
`timescale 1ns / 1ps
module bf16_rotary_embedding_pair_unit_tb;
   import rope_pkg::*;

   localparam int RANDOM_ITEMS = 435;
   localparam int CYCLE_LIMIT  = 100000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_q_first = '0;
   logic [15:0] req_q_second = '0;
   logic [15:0] req_k_first = '0;
   logic [15:0] req_k_second = '0;
   logic [15:0] req_cos_val = '0;
   logic [15:0] req_sin_val = '0;
   logic        rsp_valid;
   logic [15:0] rsp_q_rot_first, rsp_q_rot_second, rsp_k_rot_first, rsp_k_rot_second;
   int          fail_count, outstanding;
   int          cycles = 0;

   bf16_rotary_embedding_pair_unit dut (.*);
   bf16_rotary_embedding_pair_unit_checker checker_i (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** bf16_rotary_embedding_pair_unit: FAILED **");
         $finish;
      end
   end

   // Present one item and hold it until the block takes the transfer.
   // An idle gap follows about one item in eleven when may_idle is set.
   task automatic send_item(input bit [15:0] qf, input bit [15:0] qs, input bit [15:0] kf,
                            input bit [15:0] ks, input bit [15:0] cv, input bit [15:0] sv,
                            input bit may_idle);
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_q_first <= qf;
      req_q_second <= qs;
      req_k_first <= kf;
      req_k_second <= ks;
      req_cos_val <= cv;
      req_sin_val <= sv;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (may_idle && $urandom_range(99) < 9) begin
         gap = $urandom_range(4, 1);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic bit [15:0] plausible_bf16(input int lo_exp, input int hi_exp);
      return {1'($urandom), 8'($urandom_range(hi_exp, lo_exp)), 7'($urandom)};
   endfunction

   initial begin
      bit [15:0] vec [15][6] = '{
         '{16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h3F80, 16'h0000},
         '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
         '{16'h7F80, 16'h0000, 16'hFF80, 16'h3F80, 16'h0000, 16'h3F80},
         '{16'h7FC0, 16'h3F80, 16'h7F81, 16'h0000, 16'h3F80, 16'h3F80},
         '{16'h7F80, 16'h7F80, 16'hFF80, 16'h7F80, 16'h3F80, 16'h3F80},
         '{16'h3F80, 16'h3F80, 16'h4000, 16'h4000, 16'h3F80, 16'h3F80},
         '{16'h7F7F, 16'h7F7F, 16'hFF7F, 16'h7F7F, 16'h7F7F, 16'h7F7F},
         '{16'h0001, 16'h007F, 16'h8001, 16'h0080, 16'h3F80, 16'h3F00},
         '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
         '{16'h7F7F, 16'h0000, 16'h0000, 16'h7F7F, 16'h3F80, 16'h0000},
         '{16'h3FC0, 16'h3F81, 16'hBF81, 16'h3F80, 16'h3F7F, 16'h3C00},
         '{16'h4049, 16'hC049, 16'h4049, 16'h4049, 16'h3F35, 16'h3F35},
         '{16'h7F7F, 16'h7F7F, 16'h7F7F, 16'h7F7F, 16'h3F80, 16'h3F80},
         '{16'h0080, 16'h0080, 16'h8080, 16'h0080, 16'h3F00, 16'h3F00}
      };
      int waited;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (vec[i])
         send_item(vec[i][0], vec[i][1], vec[i][2], vec[i][3], vec[i][4], vec[i][5], 1'b1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Items 150 to 249 go back to back with no idle cycles.
         if ($urandom_range(1)) begin
            send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      n < 150 || n >= 250);
         end else begin
            send_item(plausible_bf16(100, 150), plausible_bf16(100, 150),
                      plausible_bf16(100, 150), plausible_bf16(100, 150),
                      plausible_bf16(110, 127), plausible_bf16(110, 127),
                      n < 150 || n >= 250);
         end
      end
      @(negedge clock);
      start <= 1'b0;

      waited = 0;
      while ((outstanding != 0 || waited < LATENCY + 4) && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      if (fail_count == 0 && outstanding == 0) begin
         $display("** bf16_rotary_embedding_pair_unit: PASSED **");
      end else begin
         $display("** bf16_rotary_embedding_pair_unit: FAILED **");
      end
      $finish;
   end

endmodule
